// ===== rtl/core/set_assoc_lru_cache_tag_policy_core_assert.svh =====
// Assertion macros for the cache tag policy core.
`ifndef SET_ASSOC_LRU_CACHE_TAG_POLICY_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAG_POLICY_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SALC_ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define SALC_ASSERT(label, prop, msg) \
  `SALC_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define SALC_ASSERT_CLK(label, ck, rs, prop, msg)
`define SALC_ASSERT(label, prop, msg)
`endif
`endif

// ===== rtl/core/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, codes and types of the set-associative cache tag core.
// ----------------------------------------------------------------------------
`default_nettype none
package salc_pkg;

  localparam int TOTAL_LINES_DEF = 512;
  localparam int LINE_BYTES_DEF  = 32;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b1;

  localparam logic [1:0] MODE_ALLOCATE = 2'd0;
  localparam logic [1:0] MODE_NO_WALLOC = 2'd1;
  localparam logic [1:0] MODE_PF_ALWAYS = 2'd2;
  localparam logic [1:0] MODE_PF_MISS   = 2'd3;

  localparam logic REQ_STORE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_END,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/salc_channels.sv =====
// ----------------------------------------------------------------------------
// salc_channels
// Valid/ready channels of the cache tag core: request, result, configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface salc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [salc_pkg::ADDR_W-1:0] address;
  modport source (output valid, req_type, address, input ready);
  modport sink   (input valid, req_type, address, output ready);
endinterface

interface salc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [salc_pkg::COUNT_W-1:0] hit_count;
  modport source (output valid, hit, hit_count, input ready);
  modport sink   (input valid, hit, hit_count, output ready);
endinterface

interface salc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [salc_pkg::CFG_IDX_W-1:0]  addr;
  logic [salc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_tag_policy_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_policy_core
// Set-associative tag store with true LRU ranks and optional next-line
// prefetch, walked one way per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                 Beat taken when
// req      in   req_type, address       req.valid & req.ready
// rsp      out  hit, hit_count          rsp.valid & rsp.ready
// cfg      in   addr, data              cfg.valid & cfg.ready
//
// Each lookup reads the set one way per cycle from the tag RAM (scan), then,
// on a hit or an allocation, rewrites it one way per cycle (rank update). An
// item takes one lookup, or two with a prefetch, plus the accept and hand-off
// states. After reset and after every ways_log2 write a clearing pass over
// all TOTAL_LINES lines runs, during which no request is taken. A stalled
// result waits in the output register; the next request is taken meanwhile,
// and that item holds in its hand-off cycle until the register frees.
// TOTAL_LINES and LINE_BYTES must be powers of two.
`default_nettype none
`include "set_assoc_lru_cache_tag_policy_core_assert.svh"
module set_assoc_lru_cache_tag_policy_core #(
  parameter int TOTAL_LINES = salc_pkg::TOTAL_LINES_DEF,
  parameter int LINE_BYTES  = salc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS   = salc_pkg::ADDR_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  salc_req_if.sink   req,
  salc_rsp_if.source rsp,
  salc_cfg_if.sink   cfg
);
  import salc_pkg::*;

  localparam int IDX_W = $clog2(TOTAL_LINES);
  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int TAG_W = ADDR_BITS - OFF_W;
  localparam int ENT_W = 1 + TAG_W + IDX_W;

  state_t state, state_next;

  logic [3:0]           ways_log2;
  logic [1:0]           policy_mode;
  logic                 phase;
  logic                 is_store;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [TAG_W-1:0]     acc_tag;
  logic [IDX_W-1:0]     set_base;
  logic [IDX_W-1:0]     idx, idx_d;
  logic                 issue_done, vld_d;
  logic                 found_hit, found_inv;
  logic [IDX_W-1:0]     hit_way, inv_way, vic_way, tgt_way;
  logic [IDX_W-1:0]     hit_rank, vic_rank, tgt_rank;
  logic                 tgt_valid;
  logic                 demand_hit;
  logic [COUNT_W-1:0]   hits_total;
  logic                 rsp_valid, rsp_hit;
  logic [COUNT_W-1:0]   rsp_count;

  logic [3:0]           wl;
  logic [IDX_W-1:0]     ways_m1;
  logic [ADDR_BITS-1:0] line_no;
  logic                 allocate, want_pf, scan_last;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;
  logic                 rd_valid;
  logic [TAG_W-1:0]     rd_tag;
  logic [IDX_W-1:0]     rd_rank;
  logic                 bump;

  // A ways_log2 beyond log2 of the line count means fully associative.
  assign wl       = (ways_log2 > 4'(IDX_W)) ? 4'(IDX_W) : ways_log2;
  assign ways_m1  = ~({IDX_W{1'b1}} << wl);
  assign line_no  = cur_addr >> OFF_W;
  assign allocate = phase || !(policy_mode == MODE_NO_WALLOC && is_store == REQ_STORE);
  assign want_pf  = !phase && (policy_mode == MODE_PF_ALWAYS ||
                               (policy_mode == MODE_PF_MISS && !demand_hit));
  assign scan_last = vld_d && (idx_d == ways_m1);

  assign rd_valid = ram_rdata[ENT_W-1];
  assign rd_tag   = ram_rdata[IDX_W +: TAG_W];
  assign rd_rank  = ram_rdata[IDX_W-1:0];
  assign ram_raddr = set_base | idx;
  assign bump = rd_valid && (!tgt_valid || rd_rank < tgt_rank);

  salc_ram #(.WIDTH(ENT_W), .DEPTH(TOTAL_LINES)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (idx == {IDX_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_START;
      ST_START:  state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = (found_hit || allocate) ? ST_UPDATE : ST_END;
      ST_UPDATE: if (scan_last) state_next = ST_END;
      ST_END:    state_next = want_pf ? ST_START : ST_DONE;
      ST_DONE:   if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
    if (cfg.valid && cfg.addr == CFG_WAYS_LOG2) begin
      state_next = ST_CLEAR;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_base | idx_d;
    ram_wdata = '0;
    req.ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
      end
      ST_IDLE: req.ready = 1'b1;
      ST_UPDATE: begin
        ram_we = vld_d;
        if (idx_d == tgt_way) begin
          ram_wdata = {1'b1, acc_tag, {IDX_W{1'b0}}};
        end else begin
          ram_wdata = {rd_valid, rd_tag, rd_rank + IDX_W'(bump)};
        end
      end
      default: ;
    endcase
  end

  assign cfg.ready     = 1'b1;
  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.hit_count = rsp_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      ways_log2   <= '0;
      policy_mode <= MODE_ALLOCATE;
      idx         <= '0;
      hits_total  <= '0;
      rsp_valid   <= 1'b0;
      vld_d       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          // A new geometry restarts the pass from line zero.
          if (!(cfg.valid && cfg.addr == CFG_WAYS_LOG2)) idx <= idx + 1'b1;
        end
        ST_IDLE: begin
          if (req.valid) begin
            phase    <= 1'b0;
            is_store <= req.req_type;
            cur_addr <= ADDR_BITS'(req.address);
          end
        end
        ST_START: begin
          acc_tag    <= TAG_W'(cur_addr >> (OFF_W + IDX_W - int'(wl)));
          set_base   <= IDX_W'(line_no << wl);
          idx        <= '0;
          issue_done <= 1'b0;
          vld_d      <= 1'b0;
          found_hit  <= 1'b0;
          found_inv  <= 1'b0;
          vic_way    <= '0;
          vic_rank   <= '0;
        end
        ST_SCAN, ST_UPDATE: begin
          if (!issue_done) begin
            idx <= idx + 1'b1;
            if (idx == ways_m1) issue_done <= 1'b1;
          end
          vld_d <= !issue_done;
          idx_d <= idx;
          if (state == ST_SCAN && vld_d) begin
            if (rd_valid && rd_tag == acc_tag && !found_hit) begin
              found_hit <= 1'b1;
              hit_way   <= idx_d;
              hit_rank  <= rd_rank;
            end
            if (!rd_valid && !found_inv) begin
              found_inv <= 1'b1;
              inv_way   <= idx_d;
            end
            // Oldest valid way; ties keep the lowest way.
            if (idx_d == '0 || rd_rank > vic_rank) begin
              vic_way  <= idx_d;
              vic_rank <= rd_rank;
            end
          end
        end
        ST_DECIDE: begin
          idx        <= '0;
          issue_done <= 1'b0;
          vld_d      <= 1'b0;
          if (found_hit) begin
            tgt_way   <= hit_way;
            tgt_valid <= 1'b1;
            tgt_rank  <= hit_rank;
          end else if (found_inv) begin
            tgt_way   <= inv_way;
            tgt_valid <= 1'b0;
            tgt_rank  <= '0;
          end else begin
            tgt_way   <= vic_way;
            tgt_valid <= 1'b1;
            tgt_rank  <= vic_rank;
          end
          if (!phase) begin
            demand_hit <= found_hit;
            if (found_hit) hits_total <= hits_total + 1'b1;
          end
        end
        ST_END: begin
          phase    <= 1'b1;
          cur_addr <= cur_addr + ADDR_BITS'(LINE_BYTES);
        end
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_hit   <= demand_hit;
            rsp_count <= hits_total;
          end
        end
        default: ;
      endcase
      if (cfg.valid) begin
        case (cfg.addr)
          CFG_WAYS_LOG2: begin
            ways_log2 <= cfg.data;
            idx       <= '0;
          end
          CFG_POLICY_MODE: policy_mode <= cfg.data[1:0];
          default: ;
        endcase
      end
    end
  end

  `SALC_ASSERT(a_no_result_next_cycle, (req.valid && req.ready) |=> !$rose(rsp.valid),
               "result appeared one cycle after a request")
  `SALC_ASSERT(a_no_write_in_scan, (state == ST_SCAN) |-> !ram_we,
               "tag RAM written during a scan")
  `SALC_ASSERT(a_hits_step, 1'b1 |=> (hits_total == $past(hits_total) ||
               hits_total == $past(hits_total) + 1'b1),
               "hit total moved by more than one")
endmodule
`default_nettype wire

// ===== verif/tb_set_assoc_lru_cache_tag_policy_core.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tag_policy_core
// Self-checking bench for the set-associative LRU tag core. Each phase
// programs associativity and policy while the core is idle. It then sends
// directed and random loads and stores, mostly to a few hot sets so that
// hits, conflicts and evictions are frequent. A behavioral tag store
// predicts hit and hit count for every accepted beat, and the monitor
// compares each returned beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_set_assoc_lru_cache_tag_policy_core;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  localparam int NLINES    = 512;
  localparam int MAX_WL    = 9;
  localparam int IDLE_WAIT = 2200;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic clk;
  logic rst;

  salc_req_if req ();
  salc_rsp_if rsp ();
  salc_cfg_if cfg ();

  set_assoc_lru_cache_tag_policy_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  access_t  pending_q[$];
  outcome_t outcome_q[$];
  int       errors;
  bit       quiet;
  bit       done;

  // Behavioral copy of the tag store.
  bit           line_v[NLINES];
  logic [31:0]  line_t[NLINES];
  int           line_r[NLINES];
  logic [31:0]  hits_seen;
  int           assoc_log2;
  logic [1:0]   mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_pending(access_t a);
    pending_q = {pending_q, a};
  endfunction

  function automatic void add_outcome(outcome_t o);
    outcome_q = {outcome_q, o};
  endfunction

  function automatic void promote(int base, int ways, int w);
    bit was_v;
    int old;
    was_v = line_v[base + w];
    old   = line_r[base + w];
    for (int v = 0; v < ways; v++) begin
      if (v != w && line_v[base + v]) begin
        if ((!was_v || line_r[base + v] < old) && line_r[base + v] < 'hFFFF)
          line_r[base + v]++;
      end
    end
    line_v[base + w] = 1'b1;
    line_r[base + w] = 0;
  endfunction

  function automatic bit lookup_line(logic [31:0] a, bit fill);
    int wl, ways, sets, base, victim;
    logic [31:0] tg;
    wl   = (assoc_log2 > MAX_WL) ? MAX_WL : assoc_log2;
    ways = 1 << wl;
    sets = NLINES >> wl;
    tg   = a >> (5 + MAX_WL - wl);
    base = ((a >> 5) % sets) * ways;
    for (int w = 0; w < ways; w++) begin
      if (line_v[base + w] && line_t[base + w] == tg) begin
        promote(base, ways, w);
        return 1'b1;
      end
    end
    if (!fill) return 1'b0;
    for (int w = 0; w < ways; w++) begin
      if (!line_v[base + w]) begin
        line_t[base + w] = tg;
        promote(base, ways, w);
        return 1'b0;
      end
    end
    victim = 0;
    for (int w = 1; w < ways; w++) begin
      if (line_r[base + w] > line_r[base + victim]) victim = w;
    end
    line_t[base + victim] = tg;
    promote(base, ways, victim);
    return 1'b0;
  endfunction

  function automatic outcome_t access_cache(access_t acc);
    outcome_t o;
    bit fill;
    fill  = !(mode == MODE_NO_WALLOC && acc.kind == REQ_STORE);
    o.hit = lookup_line(acc.addr, fill);
    if (o.hit) hits_seen++;
    if (mode == MODE_PF_ALWAYS || (mode == MODE_PF_MISS && !o.hit))
      void'(lookup_line(acc.addr + 32'd32, 1'b1));
    o.count = hits_seen;
    return o;
  endfunction

  // Prediction runs on every accepted request and configuration beat.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NLINES; i++) begin
        line_v[i] = 1'b0;
        line_t[i] = '0;
        line_r[i] = 0;
      end
      hits_seen  = '0;
      assoc_log2 = 0;
      mode       = MODE_ALLOCATE;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.addr == CFG_WAYS_LOG2) begin
          assoc_log2 = int'(cfg.data);
          for (int i = 0; i < NLINES; i++) begin
            line_v[i] = 1'b0;
            line_r[i] = 0;
          end
        end else if (cfg.addr == CFG_POLICY_MODE) begin
          mode = cfg.data[1:0];
        end
      end
      if (req.valid && req.ready)
        add_outcome(access_cache('{req.req_type, req.address}));
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // After an accepted beat a fresh gap is drawn; a separate draw decides
  // whether the stream stays back to back, otherwise valid drops for the gap.
  function automatic bit send_gap_nonzero();
    return ($urandom_range(0, 99) >= 55) && !quiet;
  endfunction

  int send_gap;
  always @(posedge clk) begin
    access_t nxt;
    if (rst) begin
      req.valid    <= 1'b0;
      req.req_type <= 1'b0;
      req.address  <= '0;
      send_gap     <= 0;
    end else if (!(req.valid && !req.ready)) begin
      if (req.valid) send_gap <= pick_gap();
      if (send_gap > 0 && !req.valid) begin
        send_gap  <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_q.size() > 0 && !(req.valid && send_gap_nonzero())) begin
        nxt = pending_q.pop_front();
        req.valid    <= 1'b1;
        req.req_type <= nxt.kind;
        req.address  <= nxt.addr;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  int stall;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall     <= 0;
    end else if (stall > 0) begin
      stall     <= stall - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (rsp.valid && rsp.ready) stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0b hit_count=%0d",
                 $time, rsp.hit, rsp.hit_count);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (rsp.hit !== want.hit) begin
          $display("%0t: hit mismatch expected %0b actual %0b",
                   $time, want.hit, rsp.hit);
          errors++;
        end
        if (rsp.hit_count !== want.count) begin
          $display("%0t: hit_count mismatch expected %0d actual %0d",
                   $time, want.count, rsp.hit_count);
          errors++;
        end
      end
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (!done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("FAIL set_assoc_lru_cache_tag_policy_core");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // The falling edge sees the driver's and the monitor's updates settled.
  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() > 0 || req.valid || outcome_q.size() > 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(int wl, logic [1:0] pm, int count, bit directed, bit pause);
    logic [31:0] hot[4];
    access_t     acc;
    drain();
    write_reg(CFG_WAYS_LOG2, wl[CFG_DATA_W-1:0]);
    write_reg(CFG_POLICY_MODE, {2'b00, pm});
    quiet = ($urandom_range(0, 3) == 0);
    if (directed) begin
      // Line zero, the top line whose next line wraps to zero, repeats of each, line one and 8000_0000.
      add_pending('{1'b0, 32'h0000_0000});
      add_pending('{1'b1, 32'hFFFF_FFFF});
      add_pending('{1'b0, 32'h0000_001F});
      add_pending('{1'b1, 32'hFFFF_FFE0});
      add_pending('{1'b0, 32'h0000_0020});
      add_pending('{1'b1, 32'h8000_0000});
    end
    for (int k = 0; k < 4; k++) hot[k] = $urandom & 32'hFFFF_C000;
    for (int n = 0; n < count; n++) begin
      acc.kind = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        acc.addr = $urandom;
      end else begin
        // Few sets, several tags each: hits, conflicts and evictions.
        acc.addr = hot[$urandom_range(0, 3)] + ($urandom_range(0, 15) << 5) +
                   ($urandom_range(0, 5) << 14) + $urandom_range(0, 31);
      end
      add_pending(acc);
      if (pause && n == count / 2) begin
        do @(negedge clk);
        while (pending_q.size() > 0 || req.valid || outcome_q.size() > 0);
      end
    end
  endtask

  initial begin
    errors    = 0;
    quiet     = 1'b0;
    done      = 1'b0;
    rst       = 1'b1;
    cfg.valid = 1'b0;
    cfg.addr  = '0;
    cfg.data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    run_phase(0, MODE_ALLOCATE, 0, 1'b1, 1'b0);
    run_phase(0, MODE_NO_WALLOC, 0, 1'b1, 1'b0);
    run_phase(1, MODE_PF_ALWAYS, 0, 1'b1, 1'b0);
    run_phase(2, MODE_PF_MISS, 0, 1'b1, 1'b0);
    run_phase(3, MODE_ALLOCATE, 80, 1'b0, 1'b1);
    run_phase(2, MODE_NO_WALLOC, 80, 1'b0, 1'b0);
    run_phase(4, MODE_PF_ALWAYS, 80, 1'b0, 1'b0);
    run_phase(1, MODE_PF_MISS, 80, 1'b0, 1'b0);
    run_phase(15, MODE_PF_MISS, 40, 1'b0, 1'b0);
    run_phase(9, MODE_NO_WALLOC, 30, 1'b0, 1'b0);
    run_phase(0, MODE_PF_ALWAYS, 80, 1'b0, 1'b0);
    run_phase(6, MODE_ALLOCATE, 80, 1'b0, 1'b0);
    drain();
    done = 1'b1;
    if (outcome_q.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, outcome_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS set_assoc_lru_cache_tag_policy_core");
    end else begin
      $display("FAIL set_assoc_lru_cache_tag_policy_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/salc_pkg.sv
rtl/core/salc_channels.sv
rtl/core/salc_ram.sv
rtl/core/set_assoc_lru_cache_tag_policy_core.sv
verif/tb_set_assoc_lru_cache_tag_policy_core.sv
